// File: hw/rtl/ssl_pkg.sv
// ssl_pkg: shared types, codes and sizes for the sorted score list.
// Used by ssl_cell and sorted_score_list; depends on nothing else.

package ssl_pkg;

   // Table size and derived widths
   localparam int DEPTH    = 16;
   localparam int IDX_W    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int MAX_READ = 16;
   localparam int POS_W    = 4;
   localparam int ID_W     = 16;
   localparam int SCORE_W  = 16;

   // Request function codes
   localparam logic [1:0] FUNC_BACK   = 2'd0;
   localparam logic [1:0] FUNC_FRONT  = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Response status codes
   localparam logic [1:0] STATUS_READ     = 2'd0;
   localparam logic [1:0] STATUS_INSERTED = 2'd1;
   localparam logic [1:0] STATUS_DROPPED  = 2'd2;
   localparam logic [1:0] STATUS_REJECTED = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [ID_W-1:0]    name_id;
      logic [SCORE_W-1:0] score;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               entry_valid;
      logic [POS_W-1:0]   position;
      logic [ID_W-1:0]    out_name_id;
      logic [SCORE_W-1:0] out_score;
      logic               last;
   } rsp_type;

   // One stored table entry
   typedef struct packed {
      logic               valid;
      logic [ID_W-1:0]    name_id;
      logic [SCORE_W-1:0] score;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE
   } cell_op_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type        op;
      logic               front;
      logic [ID_W-1:0]    name_id;
      logic [SCORE_W-1:0] score;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INS_RESP,
      ST_READ
   } state_type;

endpackage

// File: hw/rtl/ssl_cell.sv
// ssl_cell: one rank of the sorted score list, holding a single entry.
// Depends on ssl_pkg for the entry and command types.

module ssl_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ssl_pkg::cell_ctl_type ctl,
   input  logic                  ahead_left,
   input  ssl_pkg::entry_type    left,
   input  ssl_pkg::entry_type    right,
   output ssl_pkg::entry_type    cur,
   output logic                  ahead,
   output logic                  fresh
);
   import ssl_pkg::*;

   entry_type entry_ff, entry_in;
   logic      fresh_ff, fresh_in;

   // Entry stays ahead of the new word: strictly higher, or equal for back insert
   always_comb begin
      if (ctl.front) begin
         ahead = entry_ff.valid && (entry_ff.score > ctl.score);
      end else begin
         ahead = entry_ff.valid && (entry_ff.score >= ctl.score);
      end
   end

   // Next entry: keep, load the new word, shift down, or rotate up
   always_comb begin
      entry_in = entry_ff;
      fresh_in = 1'b0;
      case (ctl.op)
         CELL_INSERT: begin
            if (!ahead) begin
               if (ahead_left) begin
                  entry_in.valid   = 1'b1;
                  entry_in.name_id = ctl.name_id;
                  entry_in.score   = ctl.score;
                  fresh_in         = 1'b1;
               end else begin
                  entry_in = left;
               end
            end
         end
         CELL_ROTATE: begin
            entry_in = right;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff.name_id <= entry_in.name_id;
      entry_ff.score   <= entry_in.score;
      if (reset) begin
         entry_ff.valid <= 1'b0;
         fresh_ff       <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         fresh_ff       <= fresh_in;
      end
   end

   assign cur   = entry_ff;
   assign fresh = fresh_ff;

endmodule

// File: hw/rtl/sorted_score_list.sv
// sorted_score_list: top level, a chain of ssl_cell ranks plus the sequencer.
// Depends on ssl_pkg and ssl_cell.
//
// Usage. A request word is taken on req_word at a rising edge where start is
// high and busy is low. Function back/front insert places (name_id, score) in
// descending score order, after or before equal scores. When all DEPTH ranks
// are full the lowest entry is dropped, or the new word is rejected if its
// score is not above it. A read streams the stored entries from rank 0, at
// most 16 of them, the final one flagged by last; an empty table gives one
// invalid word. Function code 3 is taken and ignored.
// Timing. Every cell compares and shifts in the accept cycle, so an insert
// updates the table at the accept edge; its response word is registered in
// the response state, busy high for one cycle. A read rotates the whole
// chain once, one rank per cycle, busy until the rotation ends; words are
// registered from rotation step 0 on, one word per cycle. The rotation length sets the read time.
// Each response is on rsp_word for exactly one cycle with rsp_strobe high;
// the receiver cannot stall it. Reset (synchronous) empties the table.

module sorted_score_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ssl_pkg::req_type req_word,
   output logic             busy,
   output logic             rsp_strobe,
   output ssl_pkg::rsp_type rsp_word
);
   import ssl_pkg::*;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  rot_ff, rot_in;
   req_type           pend_ff, pend_in;
   logic [1:0]        ins_status_ff, ins_status_in;
   rsp_type           rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;

   cell_ctl_type      ctl;
   entry_type         cells [DEPTH];
   logic [DEPTH-1:0]  ahead_vec;
   logic [DEPTH-1:0]  fresh_vec;
   logic [DEPTH-1:0]  valid_vec;

   logic              accept;
   logic              is_insert;
   logic              reject;
   logic              full;
   logic [POS_W-1:0]  ins_pos;
   logic              rot_end;
   logic              read_emit;
   logic              read_last;

   // Cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      localparam int NXT = (g == DEPTH - 1) ? 0 : g + 1;
      localparam int PRV = (g == 0) ? 0 : g - 1;
      logic      ahead_left;
      entry_type left;

      assign ahead_left = (g == 0) ? 1'b1 : ahead_vec[PRV];
      assign left       = cells[PRV];

      ssl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .ahead_left (ahead_left),
         .left       (left),
         .right      (cells[NXT]),
         .cur        (cells[g]),
         .ahead      (ahead_vec[g]),
         .fresh      (fresh_vec[g])
      );

      assign valid_vec[g] = cells[g].valid;
   end

   // Request decode and full-table check
   assign accept    = start && !busy;
   assign is_insert = (req_word.func == FUNC_BACK) || (req_word.func == FUNC_FRONT);
   assign full      = cells[DEPTH-1].valid;
   assign reject    = full && (req_word.score <= cells[DEPTH-1].score);

   // Rank of the new word from the one-hot fresh marks
   always_comb begin
      ins_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         ins_pos = ins_pos | (fresh_vec[i] ? POS_W'(i) : '0);
      end
   end

   // Read stream conditions at rotation step rot_ff
   assign rot_end   = (rot_ff == IDX_W'(DEPTH - 1));
   assign read_emit = (rot_ff == '0) ||
                      (cells[0].valid && (32'(rot_ff) < MAX_READ));
   assign read_last = !cells[0].valid || !cells[1 % DEPTH].valid || rot_end ||
                      (32'(rot_ff) == MAX_READ - 1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_insert) begin
               state_in = ST_INS_RESP;
            end else if (accept && (req_word.func == FUNC_READ)) begin
               state_in = ST_READ;
            end
         end
         ST_INS_RESP: begin
            state_in = ST_IDLE;
         end
         ST_READ: begin
            if (rot_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: cell command, pending word, response
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      ctl.op        = CELL_HOLD;
      ctl.front     = (req_word.func == FUNC_FRONT);
      ctl.name_id   = req_word.name_id;
      ctl.score     = req_word.score;
      pend_in       = pend_ff;
      ins_status_in = ins_status_ff;
      rot_in        = rot_ff;
      rsp_in        = rsp_ff;
      strobe_in     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            rot_in = '0;
            if (accept && is_insert) begin
               pend_in = req_word;
               if (reject) begin
                  ins_status_in = STATUS_REJECTED;
               end else begin
                  ctl.op        = CELL_INSERT;
                  ins_status_in = full ? STATUS_DROPPED : STATUS_INSERTED;
               end
            end
         end
         ST_INS_RESP: begin
            strobe_in = 1'b1;
            rsp_in.last = 1'b1;
            rsp_in.status = ins_status_ff;
            if (ins_status_ff == STATUS_REJECTED) begin
               rsp_in.entry_valid = 1'b0;
               rsp_in.position    = '0;
               rsp_in.out_name_id = '0;
               rsp_in.out_score   = '0;
            end else begin
               rsp_in.entry_valid = 1'b1;
               rsp_in.position    = ins_pos;
               rsp_in.out_name_id = pend_ff.name_id;
               rsp_in.out_score   = pend_ff.score;
            end
         end
         ST_READ: begin
            ctl.op             = CELL_ROTATE;
            rot_in             = rot_ff + 1'b1;
            strobe_in          = read_emit;
            rsp_in.status      = STATUS_READ;
            rsp_in.entry_valid = cells[0].valid;
            rsp_in.position    = cells[0].valid ? POS_W'(rot_ff) : '0;
            rsp_in.out_name_id = cells[0].valid ? cells[0].name_id : '0;
            rsp_in.out_score   = cells[0].valid ? cells[0].score : '0;
            rsp_in.last        = read_last;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      ins_status_ff <= ins_status_in;
      rsp_ff        <= rsp_in;
      rot_ff        <= rot_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

   // Table stays packed from rank 0 whenever the block is idle
   a_packed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (((valid_vec >> 1) & ~valid_vec) == '0))
      else $error("table has a hole");

   // At most one cell marks the newly inserted word
   a_fresh_one: assert property (@(posedge clock) disable iff (reset)
      $onehot0(fresh_vec))
      else $error("more than one fresh cell");

   // Every accepted insert or read is answered with a strobed response word
   a_first_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (is_insert || (req_word.func == FUNC_READ))) |-> ##2 rsp_strobe)
      else $error("missing first response word");

   // Insert responses are always single words
   a_ins_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.status != STATUS_READ)) |-> rsp_word.last)
      else $error("insert response without last");

   // A successful insert leaves the table non-empty
   a_ins_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_RESP && ins_status_ff != STATUS_REJECTED) |-> valid_vec[0])
      else $error("insert left table empty");

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for sorted_score_list (insert, overflow, read-out).
// Depends on ssl_pkg and the sorted_score_list RTL; a local table model predicts
// every response word, which a monitor compares as the words stream out.
`timescale 1ns / 100ps

module tb;
   import ssl_pkg::*;

   localparam int CYCLE_LIMIT = 100000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_word;

   // Local copy of the ranked table
   logic [SCORE_W-1:0] rank_score [DEPTH];
   logic [ID_W-1:0]    rank_name  [DEPTH];
   int                 rank_count = 0;

   rsp_type awaited_words [$];
   int      error_count = 0;
   int      cycle_count = 0;

   sorted_score_list dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_word   (req_word),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic void push_word(input logic [1:0] status, input logic valid,
                                     input int pos, input logic [ID_W-1:0] name,
                                     input logic [SCORE_W-1:0] score, input logic last);
      rsp_type w;
      w.status      = status;
      w.entry_valid = valid;
      w.position    = POS_W'(pos);
      w.out_name_id = name;
      w.out_score   = score;
      w.last        = last;
      awaited_words.push_back(w);
   endfunction

   // Apply one accepted request to the table and queue the words it produces
   function automatic void table_apply(input req_type w);
      int  pos;
      int  n;
      bit  ahead;
      logic [1:0] status;
      case (w.func)
         FUNC_BACK, FUNC_FRONT: begin
            pos = 0;
            for (int i = 0; i < rank_count; i++) begin
               ahead = (w.func == FUNC_FRONT) ? (rank_score[i] > w.score)
                                              : (rank_score[i] >= w.score);
               if (ahead)
                  pos++;
            end
            if (rank_count == DEPTH && w.score <= rank_score[DEPTH-1]) begin
               push_word(STATUS_REJECTED, 1'b0, 0, '0, '0, 1'b1);
            end else begin
               status = STATUS_INSERTED;
               if (rank_count == DEPTH) begin
                  status     = STATUS_DROPPED;
                  rank_count = DEPTH - 1;
               end
               for (int i = rank_count; i > pos; i--) begin
                  rank_score[i] = rank_score[i-1];
                  rank_name[i]  = rank_name[i-1];
               end
               rank_score[pos] = w.score;
               rank_name[pos]  = w.name_id;
               rank_count++;
               push_word(status, 1'b1, pos, w.name_id, w.score, 1'b1);
            end
         end
         FUNC_READ: begin
            n = (rank_count > MAX_READ) ? MAX_READ : rank_count;
            if (n == 0)
               push_word(STATUS_READ, 1'b0, 0, '0, '0, 1'b1);
            for (int i = 0; i < n; i++)
               push_word(STATUS_READ, 1'b1, i, rank_name[i], rank_score[i], i == n - 1);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string field, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0h, got %0h", field, exp_v, act_v);
         error_count++;
      end
   endfunction

   // Response monitor: every strobed word is matched against the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_w;
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_words.size() == 0) begin
            $error("unexpected word: status %0d name %0h score %0h",
                   rsp_word.status, rsp_word.out_name_id, rsp_word.out_score);
            error_count++;
         end else begin
            exp_w = awaited_words.pop_front();
            check_field("status", exp_w.status, rsp_word.status);
            check_field("entry_valid", exp_w.entry_valid, rsp_word.entry_valid);
            check_field("position", exp_w.position, rsp_word.position);
            check_field("out_name_id", exp_w.out_name_id, rsp_word.out_name_id);
            check_field("out_score", exp_w.out_score, rsp_word.out_score);
            check_field("last", exp_w.last, rsp_word.last);
         end
      end
   end

   // Present one request word and hold it until the block takes it
   task automatic send_word(input logic [1:0] func, input logic [ID_W-1:0] name,
                            input logic [SCORE_W-1:0] score);
      req_type w;
      w.func    = func;
      w.name_id = name;
      w.score   = score;
      req_word <= w;
      start    <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      table_apply(w);
   endtask

   // Random sender gaps; pct is the chance of one more idle cycle
   task automatic idle_gap(input int pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_for_words();
      start <= 1'b0;
      while (awaited_words.size() != 0)
         @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
   endtask

   task automatic test_empty_and_unused();
      send_word(FUNC_READ, 16'h0000, 16'h0000);
      send_word(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
   endtask

   // Extremes and tie ordering on a partly filled table
   task automatic test_partial_ordering();
      send_word(FUNC_BACK, 16'hFFFF, 16'hFFFF);
      send_word(FUNC_BACK, 16'h0000, 16'h0000);
      send_word(FUNC_FRONT, 16'h0001, 16'd100);
      send_word(FUNC_BACK, 16'h0002, 16'd100);
      send_word(FUNC_FRONT, 16'h0003, 16'd100);
      send_word(FUNC_READ, 16'h1234, 16'h4321);
   endtask

   // Fill all ranks, then reject on ties, drop on higher scores
   task automatic test_fill_and_overflow();
      logic [SCORE_W-1:0] fill_scores [11] = '{16'd500, 16'd100, 16'd7, 16'hFFFF, 16'd1,
                                              16'd7, 16'd30000, 16'd1, 16'd9999,
                                              16'd500, 16'd2};
      for (int i = 0; i < 11; i++)
         send_word(i[0] ? FUNC_FRONT : FUNC_BACK, 16'h0100 + ID_W'(i), fill_scores[i]);
      send_word(FUNC_BACK, 16'hAAAA, 16'd0);
      send_word(FUNC_FRONT, 16'h5555, 16'd0);
      send_word(FUNC_BACK, 16'h0BAD, 16'd1);
      send_word(FUNC_FRONT, 16'h0C0D, 16'd2);
      send_word(FUNC_READ, 16'hFFFF, 16'hFFFF);
      send_word(FUNC_UNUSED, 16'h0000, 16'h0000);
   endtask

   // Scores biased toward ties and toward the current lowest rank
   function automatic logic [SCORE_W-1:0] pick_score();
      int low;
      int v;
      case ($urandom_range(2))
         0: return SCORE_W'($urandom_range(16'hFFFF));
         1: begin
            if (rank_count == 0)
               return SCORE_W'($urandom_range(16'hFFFF));
            return rank_score[$urandom_range(rank_count - 1)];
         end
         default: begin
            low = (rank_count == 0) ? 0 : int'(rank_score[rank_count-1]);
            v   = low + int'($urandom_range(2)) - 1;
            if (v < 0)
               v = 0;
            if (v > 16'hFFFF)
               v = 16'hFFFF;
            return SCORE_W'(v);
         end
      endcase
   endfunction

   task automatic test_random_traffic(input int gap_pct, input int items);
      int sent;
      int r;
      logic [1:0] func;
      sent = 0;
      while (sent < items) begin
         r = $urandom_range(99);
         if (r < 45)
            func = FUNC_BACK;
         else if (r < 80)
            func = FUNC_FRONT;
         else if (r < 95)
            func = FUNC_READ;
         else
            func = FUNC_UNUSED;
         if (gap_pct > 0)
            idle_gap(gap_pct);
         send_word(func, ID_W'($urandom_range(16'hFFFF)), pick_score());
         if (func != FUNC_UNUSED)
            sent++;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_unused();
      test_partial_ordering();
      test_fill_and_overflow();
      test_random_traffic(0, 80);
      test_random_traffic(66, 70);
      wait_for_words();
      test_random_traffic(8, 80);
      wait_for_words();

      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
